FILE: src/rari_pkg.sv
package rari_pkg;

    // Default word geometry: signed Q16.16.
    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_AXIS   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PLANE_OFFSET = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_LOW    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_HIGH   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SECOND_LOW   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SECOND_HIGH  = 3'd5;

    // Plane selector codes; the fourth code selects nothing.
    localparam int AXIS_BITS = 2;
    localparam logic [AXIS_BITS-1:0] AXIS_XY = 2'd0;
    localparam logic [AXIS_BITS-1:0] AXIS_XZ = 2'd1;
    localparam logic [AXIS_BITS-1:0] AXIS_YZ = 2'd2;

endpackage

FILE: src/ray_axis_rect_intersect.sv
// Ray against one axis-aligned rectangle in signed fixed point. Each input beat
// is one ray and yields exactly one result beat; a miss returns all zero fields.
// The block is a single pipeline that accepts one ray per cycle while the
// output queue has room. Its depth follows the format (Q16.16 by default):
// the restoring divider for t (one quotient bit per stage) and the two
// divider chains for u and v (FRAC_BITS + 1 stages). A two-entry output queue
// decouples it from the consumer; input keeps flowing while one result waits.
// Configuration writes take effect at once and should be made while no ray is
// in flight; cfg_ready is always high.
module ray_axis_rect_intersect #(
    parameter int WORD_BITS = rari_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = rari_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rari_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]               cfg_data,
    // Ray channel.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [WORD_BITS-1:0]        origin_x,
    input  logic signed [WORD_BITS-1:0]        origin_y,
    input  logic signed [WORD_BITS-1:0]        origin_z,
    input  logic signed [WORD_BITS-1:0]        dir_x,
    input  logic signed [WORD_BITS-1:0]        dir_y,
    input  logic signed [WORD_BITS-1:0]        dir_z,
    input  logic signed [WORD_BITS-1:0]        t_lower,
    input  logic signed [WORD_BITS-1:0]        t_upper,
    // Result channel.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               is_hit,
    output logic signed [WORD_BITS-1:0]        hit_t,
    output logic [FRAC_BITS:0]                 coord_u,
    output logic [FRAC_BITS:0]                 coord_v,
    output logic signed [WORD_BITS-1:0]        point_x,
    output logic signed [WORD_BITS-1:0]        point_y,
    output logic signed [WORD_BITS-1:0]        point_z,
    output logic                               front_face
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int QW = W + F;
    localparam int PW = 2 * W;

    typedef struct packed {
        logic [W-1:0] ox, oy, oz, dx, dy, dz, tlo, thi;
    } ray_t;

    typedef struct packed {
        ray_t          ray;
        logic [W-1:0]  dvs;
        logic [W-1:0]  rem;
        logic [QW-1:0] dvd;
        logic          neg;
        logic          miss;
        logic          ff;
    } tdiv_t;

    typedef struct packed {
        ray_t         ray;
        logic [W-1:0] t;
        logic         miss;
        logic         ff;
    } tchk_t;

    typedef struct packed {
        logic [W-1:0]  ox, oy, oz, t;
        logic [PW-1:0] prx, pry, prz;
        logic          miss;
        logic          ff;
    } prod_t;

    typedef struct packed {
        logic [W-1:0] t, px, py, pz;
        logic         miss, ff, uz, vz;
        logic [W-1:0] uspan, urem, vspan, vrem;
        logic [F:0]   uq, vq;
    } uv_t;

    typedef struct packed {
        logic         hit;
        logic [W-1:0] t;
        logic [F:0]   u, v;
        logic [W-1:0] px, py, pz;
        logic         ff;
    } res_t;

    logic en;

    // Configuration registers.
    logic [rari_pkg::AXIS_BITS-1:0] axis_reg;
    logic [W-1:0] koff_reg, flo_reg, fhi_reg, slo_reg, shi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= rari_pkg::AXIS_XY;
            koff_reg <= '0;
            flo_reg  <= '0;
            fhi_reg  <= W'(1) << F;
            slo_reg  <= '0;
            shi_reg  <= W'(1) << F;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rari_pkg::CFG_PLANE_AXIS:   axis_reg <= cfg_data[rari_pkg::AXIS_BITS-1:0];
                rari_pkg::CFG_PLANE_OFFSET: koff_reg <= cfg_data;
                rari_pkg::CFG_FIRST_LOW:    flo_reg  <= cfg_data;
                rari_pkg::CFG_FIRST_HIGH:   fhi_reg  <= cfg_data;
                rari_pkg::CFG_SECOND_LOW:   slo_reg  <= cfg_data;
                rari_pkg::CFG_SECOND_HIGH:  shi_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage.
    ray_t ray_reg;
    logic ray_vld_reg;

    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ray_vld_reg <= 1'b0;
        else if (en)
            ray_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ray_reg <= '{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper};
    end

    // Select the normal axis and set up the unsigned division for t.
    tdiv_t        prep_next;
    logic [W-1:0] on_sel, dn_sel;
    logic         bad_axis;
    logic [W:0]   num_full, num_abs, dn_abs;

    always_comb
    begin
        bad_axis = 1'b0;
        case (axis_reg)
            rari_pkg::AXIS_XY:
            begin
                on_sel = ray_reg.oz;
                dn_sel = ray_reg.dz;
            end
            rari_pkg::AXIS_XZ:
            begin
                on_sel = ray_reg.oy;
                dn_sel = ray_reg.dy;
            end
            rari_pkg::AXIS_YZ:
            begin
                on_sel = ray_reg.ox;
                dn_sel = ray_reg.dx;
            end
            default:
            begin
                on_sel   = ray_reg.ox;
                dn_sel   = ray_reg.dx;
                bad_axis = 1'b1;
            end
        endcase
        num_full = {koff_reg[W-1], koff_reg} - {on_sel[W-1], on_sel};
        num_abs  = num_full[W] ? -num_full : num_full;
        dn_abs   = dn_sel[W-1] ? -{dn_sel[W-1], dn_sel} : {dn_sel[W-1], dn_sel};
        prep_next.ray  = ray_reg;
        prep_next.dvs  = dn_abs[W-1:0];
        prep_next.rem  = '0;
        prep_next.dvd  = {num_abs[W-1:0], {F{1'b0}}};
        prep_next.neg  = num_full[W] ^ dn_sel[W-1];
        prep_next.miss = bad_axis || (dn_sel == '0);
        prep_next.ff   = dn_sel[W-1];
    end

    // Restoring divider for t: one quotient bit per stage.
    tdiv_t dv_reg [0:QW];
    logic  dv_vld_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (en)
            dv_vld_reg[0] <= ray_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv_reg[0] <= prep_next;
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_tdiv
        tdiv_t    dv_next;
        logic [W:0] sh;
        logic       ge;

        always_comb
        begin
            sh      = {dv_reg[i].rem, dv_reg[i].dvd[QW-1]};
            ge      = sh >= {1'b0, dv_reg[i].dvs};
            dv_next = dv_reg[i];
            dv_next.rem = ge ? W'(sh - {1'b0, dv_reg[i].dvs}) : sh[W-1:0];
            dv_next.dvd = {dv_reg[i].dvd[QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[i+1] <= 1'b0;
            else if (en)
                dv_vld_reg[i+1] <= dv_vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dv_reg[i+1] <= dv_next;
        end
    end

    // Apply the sign to t and test it against the ray interval.
    tchk_t          tc_next, tc_reg;
    logic           tc_vld_reg;
    logic [QW:0]    t_full;
    logic [QW:0]    tlo_ext, thi_ext;

    always_comb
    begin
        t_full  = dv_reg[QW].neg ? -{1'b0, dv_reg[QW].dvd} : {1'b0, dv_reg[QW].dvd};
        tlo_ext = {{(QW+1-W){dv_reg[QW].ray.tlo[W-1]}}, dv_reg[QW].ray.tlo};
        thi_ext = {{(QW+1-W){dv_reg[QW].ray.thi[W-1]}}, dv_reg[QW].ray.thi};
        tc_next.ray  = dv_reg[QW].ray;
        tc_next.t    = t_full[W-1:0];
        tc_next.ff   = dv_reg[QW].ff;
        tc_next.miss = dv_reg[QW].miss
                    || ($signed(t_full) < $signed(tlo_ext))
                    || ($signed(t_full) > $signed(thi_ext));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tc_vld_reg <= 1'b0;
        else if (en)
            tc_vld_reg <= dv_vld_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            tc_reg <= tc_next;
    end

    // Three products t * d.
    prod_t pr_next, pr_reg;
    logic  pr_vld_reg;

    always_comb
    begin
        pr_next.ox   = tc_reg.ray.ox;
        pr_next.oy   = tc_reg.ray.oy;
        pr_next.oz   = tc_reg.ray.oz;
        pr_next.t    = tc_reg.t;
        pr_next.prx  = PW'($signed(tc_reg.t) * $signed(tc_reg.ray.dx));
        pr_next.pry  = PW'($signed(tc_reg.t) * $signed(tc_reg.ray.dy));
        pr_next.prz  = PW'($signed(tc_reg.t) * $signed(tc_reg.ray.dz));
        pr_next.miss = tc_reg.miss;
        pr_next.ff   = tc_reg.ff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_vld_reg <= 1'b0;
        else if (en)
            pr_vld_reg <= tc_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pr_reg <= pr_next;
    end

    // Hit point, bounds test, saturation and setup of the u/v division.
    uv_t           uv_first;
    logic [PW-1:0] px_full, py_full, pz_full, a_sel, b_sel;
    logic [PW-1:0] flo_ext, fhi_ext, slo_ext, shi_ext, adiff, bdiff;
    logic [W:0]    uspan, vspan;
    logic          out_bounds;

    function automatic logic [W-1:0] sat_word(input logic [PW-1:0] p);
        logic [W-1:0] r;
        if ((p[PW-1:W-1] == '0) || (p[PW-1:W-1] == '1))
            r = p[W-1:0];
        else if (p[PW-1])
            r = {1'b1, {(W-1){1'b0}}};
        else
            r = {1'b0, {(W-1){1'b1}}};
        return r;
    endfunction

    always_comb
    begin
        px_full = {{W{pr_reg.ox[W-1]}}, pr_reg.ox} + PW'($signed(pr_reg.prx) >>> F);
        py_full = {{W{pr_reg.oy[W-1]}}, pr_reg.oy} + PW'($signed(pr_reg.pry) >>> F);
        pz_full = {{W{pr_reg.oz[W-1]}}, pr_reg.oz} + PW'($signed(pr_reg.prz) >>> F);
        case (axis_reg)
            rari_pkg::AXIS_XY:
            begin
                a_sel = px_full;
                b_sel = py_full;
            end
            rari_pkg::AXIS_XZ:
            begin
                a_sel = px_full;
                b_sel = pz_full;
            end
            default:
            begin
                a_sel = py_full;
                b_sel = pz_full;
            end
        endcase
        flo_ext = {{W{flo_reg[W-1]}}, flo_reg};
        fhi_ext = {{W{fhi_reg[W-1]}}, fhi_reg};
        slo_ext = {{W{slo_reg[W-1]}}, slo_reg};
        shi_ext = {{W{shi_reg[W-1]}}, shi_reg};
        out_bounds = ($signed(a_sel) < $signed(flo_ext)) || ($signed(a_sel) > $signed(fhi_ext))
                  || ($signed(b_sel) < $signed(slo_ext)) || ($signed(b_sel) > $signed(shi_ext));
        adiff = a_sel - flo_ext;
        bdiff = b_sel - slo_ext;
        uspan = {fhi_reg[W-1], fhi_reg} - {flo_reg[W-1], flo_reg};
        vspan = {shi_reg[W-1], shi_reg} - {slo_reg[W-1], slo_reg};

        uv_first.t     = pr_reg.t;
        uv_first.px    = sat_word(px_full);
        uv_first.py    = sat_word(py_full);
        uv_first.pz    = sat_word(pz_full);
        uv_first.miss  = pr_reg.miss || out_bounds;
        uv_first.ff    = pr_reg.ff;
        uv_first.uz    = uspan[W] || (uspan == '0);
        uv_first.vz    = vspan[W] || (vspan == '0);
        uv_first.uspan = uspan[W-1:0];
        uv_first.vspan = vspan[W-1:0];
        uv_first.urem  = adiff[W-1:0];
        uv_first.vrem  = bdiff[W-1:0];
        uv_first.uq    = '0;
        uv_first.vq    = '0;
    end

    // Dividers for u and v; the quotient never exceeds one, so F + 1 bits.
    uv_t  uv_reg [0:F+1];
    logic uv_vld_reg [0:F+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            uv_vld_reg[0] <= 1'b0;
        else if (en)
            uv_vld_reg[0] <= pr_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            uv_reg[0] <= uv_first;
    end

    for (genvar j = 0; j <= F; j++)
    begin : g_uvdiv
        uv_t        uv_next;
        logic [W:0] ush, vsh;
        logic       uge, vge;

        always_comb
        begin
            if (j == 0)
            begin
                ush = {1'b0, uv_reg[j].urem};
                vsh = {1'b0, uv_reg[j].vrem};
            end
            else
            begin
                ush = {uv_reg[j].urem, 1'b0};
                vsh = {uv_reg[j].vrem, 1'b0};
            end
            uge = ush >= {1'b0, uv_reg[j].uspan};
            vge = vsh >= {1'b0, uv_reg[j].vspan};
            uv_next      = uv_reg[j];
            uv_next.urem = uge ? W'(ush - {1'b0, uv_reg[j].uspan}) : ush[W-1:0];
            uv_next.vrem = vge ? W'(vsh - {1'b0, uv_reg[j].vspan}) : vsh[W-1:0];
            uv_next.uq   = {uv_reg[j].uq[F-1:0], uge};
            uv_next.vq   = {uv_reg[j].vq[F-1:0], vge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                uv_vld_reg[j+1] <= 1'b0;
            else if (en)
                uv_vld_reg[j+1] <= uv_vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                uv_reg[j+1] <= uv_next;
        end
    end

    // Final result, zeroed on a miss.
    res_t res_next;
    uv_t  uv_last;

    always_comb
    begin
        uv_last      = uv_reg[F+1];
        res_next.hit = !uv_last.miss;
        res_next.t   = uv_last.miss ? '0 : uv_last.t;
        res_next.u   = (uv_last.miss || uv_last.uz) ? '0 : uv_last.uq;
        res_next.v   = (uv_last.miss || uv_last.vz) ? '0 : uv_last.vq;
        res_next.px  = uv_last.miss ? '0 : uv_last.px;
        res_next.py  = uv_last.miss ? '0 : uv_last.py;
        res_next.pz  = uv_last.miss ? '0 : uv_last.pz;
        res_next.ff  = uv_last.miss ? 1'b0 : uv_last.ff;
    end

    // Two-entry output queue; the pipeline advances while it has room.
    res_t       q0_reg, q1_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign en        = (cnt_reg != 2'd2);
    assign push      = en && uv_vld_reg[F+1];
    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (push && !pop)
            cnt_reg <= cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            if (cnt_reg == 2'd0)
                q0_reg <= res_next;
            else
                q1_reg <= res_next;
        end
        else if (pop && !push)
            q0_reg <= q1_reg;
        else if (pop && push)
            q0_reg <= res_next;
    end

    assign is_hit     = q0_reg.hit;
    assign hit_t      = q0_reg.t;
    assign coord_u    = q0_reg.u;
    assign coord_v    = q0_reg.v;
    assign point_x    = q0_reg.px;
    assign point_y    = q0_reg.py;
    assign point_z    = q0_reg.pz;
    assign front_face = q0_reg.ff;

endmodule
